// ===== rtl/tiled_pixel_order_mapper_defines.svh =====
// ----------------------------------------------------------------------------
// Tiled pixel order mapper assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TILED_PIXEL_ORDER_MAPPER_DEFINES_SVH
`define TILED_PIXEL_ORDER_MAPPER_DEFINES_SVH

// Same-cycle implication.
`define TPOM_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TPOM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpom_pkg.sv =====
// ----------------------------------------------------------------------------
// Tiled pixel order mapper package
// Field widths, register indexes, configuration type and window helpers.
// ----------------------------------------------------------------------------
package tpom_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned L2_W    = 5;
  localparam int unsigned COORD_W = 14;
  localparam int unsigned LIM_W   = 15;
  localparam int unsigned PIX_W   = 30;
  localparam int unsigned AREA_W  = 30;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 15;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_LOG2_SAMPLES   = 3'd0,
    CFG_WINDOW_X_FIRST = 3'd1,
    CFG_WINDOW_X_LIMIT = 3'd2,
    CFG_WINDOW_Y_FIRST = 3'd3,
    CFG_WINDOW_Y_LIMIT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [L2_W-1:0]    log2_samples;
    logic [COORD_W-1:0] window_x_first;
    logic [LIM_W-1:0]   window_x_limit;
    logic [COORD_W-1:0] window_y_first;
    logic [LIM_W-1:0]   window_y_limit;
  } cfg_t;

  // Extent of a half-open range, zero when empty.
  function automatic logic [LIM_W-1:0] span(input logic [COORD_W-1:0] first,
                                            input logic [LIM_W-1:0] limit);
    logic [LIM_W-1:0] f;
    f = LIM_W'(first);
    return (limit > f) ? (limit - f) : '0;
  endfunction

  // Pixel count of the window.
  function automatic logic [AREA_W-1:0] area(input cfg_t c);
    logic [2*LIM_W-1:0] p;
    p = span(c.window_x_first, c.window_x_limit) * span(c.window_y_first, c.window_y_limit);
    return p[AREA_W-1:0];
  endfunction

endpackage

// ===== rtl/tpom_front.sv =====
// ----------------------------------------------------------------------------
// Tiled pixel order mapper front stage
// Turns a sample position into a pixel index and checks it against the window.
// ----------------------------------------------------------------------------
module tpom_front import tpom_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [POS_W-1:0] pos_i,
  input  cfg_t             cfg_i,
  output logic             valid_o,
  output logic             ok_o,
  output logic [PIX_W-1:0] pix_o
);

  logic [AREA_W-1:0] pixels;
  logic [POS_W-1:0]  pix;
  logic              valid_q;
  logic              ok_q;
  logic [PIX_W-1:0]  pix_q;

  // Pixel index and range test against the exact pixel count.
  assign pixels = area(cfg_i);
  assign pix    = pos_i >> cfg_i.log2_samples;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q  <= pix < POS_W'(pixels);
      pix_q <= pix[PIX_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign ok_o    = ok_q;
  assign pix_o   = pix_q;

endmodule

// ===== rtl/tpom_div.sv =====
// ----------------------------------------------------------------------------
// Tiled pixel order mapper divider
// Pipelined restoring divider, one quotient bit per stage, with a side word.
// ----------------------------------------------------------------------------
module tpom_div import tpom_pkg::*; #(
  parameter int unsigned DW = 15,
  parameter int unsigned QB = 9,
  parameter int unsigned SW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DW+QB-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [QB-1:0]    quot_o,
  output logic [DW-1:0]    rem_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned NW = DW + QB;

  logic          v_q [QB];
  logic [DW-1:0] r_q [QB];
  logic [QB-1:0] q_q [QB];
  logic [DW-1:0] d_q [QB];
  logic [SW-1:0] s_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic          v_p;
    logic [DW-1:0] r_p;
    logic [QB-1:0] q_p;
    logic [DW-1:0] d_p;
    logic [SW-1:0] s_p;
    logic [DW:0]   t;
    logic          ge;
    logic [DW:0]   diff;

    // The first stage loads the high dividend bits as partial remainder.
    if (k == 0) begin : g_first
      assign v_p = valid_i;
      assign r_p = dividend_i[NW-1:QB];
      assign q_p = dividend_i[QB-1:0];
      assign d_p = divisor_i;
      assign s_p = side_i;
    end else begin : g_next
      assign v_p = v_q[k-1];
      assign r_p = r_q[k-1];
      assign q_p = q_q[k-1];
      assign d_p = d_q[k-1];
      assign s_p = s_q[k-1];
    end

    // Bring down one dividend bit and try a subtract.
    assign t    = {r_p, q_p[QB-1]};
    assign ge   = t >= {1'b0, d_p};
    assign diff = t - {1'b0, d_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        q_q[k] <= (q_p << 1) | QB'(ge);
        d_q[k] <= d_p;
        s_q[k] <= s_p;
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign quot_o  = q_q[QB-1];
  assign rem_o   = r_q[QB-1];
  assign side_o  = s_q[QB-1];

endmodule

// ===== rtl/tiled_pixel_order_mapper.sv =====
// ----------------------------------------------------------------------------
// Tiled pixel order mapper
// Maps a linear sample position to window pixel coordinates in tile order.
// ----------------------------------------------------------------------------
// One word enters per cycle and one result word leaves per cycle while the
// receiver does not stall. From input to output register there is a front
// stage, three bit-per-stage divider pipelines (tile row, tile column and row
// within the tile, of 15 - TILE_LOG2, 15 - TILE_LOG2 and TILE_LOG2 stages),
// and the output register. All stages advance together; the input is stalled
// only while the output register holds a word that the receiver stalls.
// total_samples_o follows the configuration registers directly.
`include "tiled_pixel_order_mapper_defines.svh"

module tiled_pixel_order_mapper import tpom_pkg::*; #(
  parameter int unsigned TILE_LOG2 = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CIDX_W-1:0]  cfg_index_i,
  input  logic [CDAT_W-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [POS_W-1:0]   sample_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] pixel_x_o,
  output logic [COORD_W-1:0] pixel_y_o,
  output logic               in_range_o,
  output logic [POS_W-1:0]   total_samples_o
);

  localparam int unsigned T    = TILE_LOG2;
  localparam int unsigned TILE = 1 << T;
  localparam int unsigned TW   = T + 1;
  localparam int unsigned QB1  = LIM_W - T;
  localparam int unsigned QB2  = LIM_W - T;
  localparam int unsigned SW1  = 1 + T;
  localparam int unsigned SW2  = 1 + T + QB1;
  localparam int unsigned SW3  = 1 + QB1 + QB2;

  cfg_t cfg_q;
  logic en;

  // Configuration registers; always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOG2_SAMPLES:   cfg_q.log2_samples   <= cfg_data_i[L2_W-1:0];
        CFG_WINDOW_X_FIRST: cfg_q.window_x_first <= cfg_data_i[COORD_W-1:0];
        CFG_WINDOW_X_LIMIT: cfg_q.window_x_limit <= cfg_data_i[LIM_W-1:0];
        CFG_WINDOW_Y_FIRST: cfg_q.window_y_first <= cfg_data_i[COORD_W-1:0];
        CFG_WINDOW_Y_LIMIT: cfg_q.window_y_limit <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LIM_W-1:0] width;
  logic [LIM_W-1:0] height;
  assign width  = span(cfg_q.window_x_first, cfg_q.window_x_limit);
  assign height = span(cfg_q.window_y_first, cfg_q.window_y_limit);

  // The whole pipeline moves unless a finished word is held by the receiver.
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Front stage.
  logic             f_v;
  logic             f_ok;
  logic [PIX_W-1:0] f_pix;

  tpom_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pos_i   (sample_position_i),
    .cfg_i   (cfg_q),
    .valid_o (f_v),
    .ok_o    (f_ok),
    .pix_o   (f_pix)
  );

  // Tile row: (pix >> T) / width.
  logic             d1_v;
  logic [QB1-1:0]   ty1;
  logic [LIM_W-1:0] r1;
  logic [SW1-1:0]   s1;

  tpom_div #(.DW(LIM_W), .QB(QB1), .SW(SW1)) u_div_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_v),
    .dividend_i ((LIM_W + QB1)'(f_pix >> T)),
    .divisor_i  (width),
    .side_i     ({f_ok, f_pix[T-1:0]}),
    .valid_o    (d1_v),
    .quot_o     (ty1),
    .rem_o      (r1),
    .side_o     (s1)
  );

  // Clipped height of this tile row.
  logic [LIM_W-1:0] hdiff;
  logic [TW-1:0]    th;
  assign hdiff = height - (LIM_W'(ty1) << T);
  assign th    = (hdiff >= LIM_W'(TILE)) ? TW'(TILE) : hdiff[TW-1:0];

  // Tile column: (rem >> T) / tile height.
  logic           d2_v;
  logic [QB2-1:0] tx2;
  logic [TW-1:0]  r2;
  logic [SW2-1:0] s2;

  tpom_div #(.DW(TW), .QB(QB2), .SW(SW2)) u_div_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (d1_v),
    .dividend_i ({1'b0, r1}),
    .divisor_i  (th),
    .side_i     ({s1, ty1}),
    .valid_o    (d2_v),
    .quot_o     (tx2),
    .rem_o      (r2),
    .side_o     (s2)
  );

  // Clipped width of this tile column.
  logic [LIM_W-1:0] wdiff;
  logic [TW-1:0]    tw;
  assign wdiff = width - (LIM_W'(tx2) << T);
  assign tw    = (wdiff >= LIM_W'(TILE)) ? TW'(TILE) : wdiff[TW-1:0];

  // Row and column inside the tile.
  logic           d3_v;
  logic [T-1:0]   dy3;
  logic [TW-1:0]  r3;
  logic [SW3-1:0] s3;

  tpom_div #(.DW(TW), .QB(T), .SW(SW3)) u_div_pix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (d2_v),
    .dividend_i ({1'b0, r2[T-1:0], s2[QB1+T-1:QB1]}),
    .divisor_i  (tw),
    .side_i     ({s2[SW2-1], s2[QB1-1:0], tx2}),
    .valid_o    (d3_v),
    .quot_o     (dy3),
    .rem_o      (r3),
    .side_o     (s3)
  );

  // Final coordinates, zero when out of range.
  logic               ok3;
  logic [COORD_W-1:0] x_sum;
  logic [COORD_W-1:0] y_sum;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic               ok_q;

  assign ok3   = s3[SW3-1];
  assign x_sum = cfg_q.window_x_first + (COORD_W'(s3[QB2-1:0]) << T)
               + COORD_W'(r3[T-1:0]);
  assign y_sum = cfg_q.window_y_first + (COORD_W'(s3[QB2+QB1-1:QB2]) << T)
               + COORD_W'(dy3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= ok3;
      x_q  <= ok3 ? x_sum : '0;
      y_q  <= ok3 ? y_sum : '0;
    end
  end

  // Saturated total sample count.
  logic [2*POS_W-1:0] total_wide;
  assign total_wide = (2*POS_W)'(area(cfg_q)) << cfg_q.log2_samples;

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = x_q;
  assign pixel_y_o       = y_q;
  assign in_range_o      = ok_q;
  assign total_samples_o = (|total_wide[2*POS_W-1:POS_W]) ? '1 : total_wide[POS_W-1:0];

  // Checks.
  `TPOM_ASSERT(a_oor_zero, out_valid_o && !in_range_o, pixel_x_o == '0 && pixel_y_o == '0, "out of range word has nonzero coordinates")
  `TPOM_ASSERT(a_x_in_window, out_valid_o && in_range_o && cfg_q.window_x_limit <= LIM_W'(16384), pixel_x_o >= cfg_q.window_x_first && LIM_W'(pixel_x_o) < cfg_q.window_x_limit, "column outside window")
  `TPOM_ASSERT(a_y_in_window, out_valid_o && in_range_o && cfg_q.window_y_limit <= LIM_W'(16384), pixel_y_o >= cfg_q.window_y_first && LIM_W'(pixel_y_o) < cfg_q.window_y_limit, "row outside window")
  `TPOM_ASSERT(a_range_total, out_valid_o && in_range_o, total_samples_o != '0, "in range word with empty window")
  `TPOM_ASSERT(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without a held output word")
  `TPOM_ASSERT_NEXT(a_front_load, in_valid_i && !in_stall_o, f_v, "accepted word missing from front stage")

endmodule

// ===== tb/tiled_pixel_order_mapper_test.sv =====
// ----------------------------------------------------------------------------
// Tiled pixel order mapper testbench
// Streams sample positions through the mapper under several window settings
// and checks each result word against a tile-order predictor.
// ----------------------------------------------------------------------------
module tiled_pixel_order_mapper_test;
  import tpom_pkg::*;

  localparam int unsigned TILE_SIDE  = 32;
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT = 40;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               in_range;
    logic [POS_W-1:0]   total;
  } pixel_word_t;

  // Scoreboard: keeps its own copy of the window settings and the queue of
  // pixel words still due from the block.
  class pixel_scoreboard;
    logic [L2_W-1:0]    l2;
    logic [COORD_W-1:0] xf;
    logic [LIM_W-1:0]   xl;
    logic [COORD_W-1:0] yf;
    logic [LIM_W-1:0]   yl;
    pixel_word_t        due_q[$];

    function void set_reg(cfg_idx_e idx, logic [CDAT_W-1:0] val);
      case (idx)
        CFG_LOG2_SAMPLES:   l2 = val[L2_W-1:0];
        CFG_WINDOW_X_FIRST: xf = val[COORD_W-1:0];
        CFG_WINDOW_X_LIMIT: xl = val[LIM_W-1:0];
        CFG_WINDOW_Y_FIRST: yf = val[COORD_W-1:0];
        CFG_WINDOW_Y_LIMIT: yl = val[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Exact (unsaturated) sample count of the window.
    function longint unsigned exact_total();
      longint unsigned w, h;
      w = (xl > xf) ? longint'(xl) - longint'(xf) : 0;
      h = (yl > yf) ? longint'(yl) - longint'(yf) : 0;
      return (w * h) << l2;
    endfunction

    // Work out the pixel that holds an accepted position.
    function void note_position(logic [POS_W-1:0] pos);
      longint unsigned w, h, pix, tot, rs, ty, rem, th, ft, tx, r2, tw, dy, dx;
      longint unsigned x, y;
      pixel_word_t     e;
      w   = (xl > xf) ? longint'(xl) - longint'(xf) : 0;
      h   = (yl > yf) ? longint'(yl) - longint'(yf) : 0;
      tot = (w * h) << l2;
      pix = longint'(pos) >> l2;
      x   = 0;
      y   = 0;
      e.in_range = pix < w * h;
      if (e.in_range) begin
        rs  = w * TILE_SIDE;
        ty  = pix / rs;
        rem = pix - ty * rs;
        th  = (h - ty * TILE_SIDE < TILE_SIDE) ? h - ty * TILE_SIDE : TILE_SIDE;
        ft  = TILE_SIDE * th;
        tx  = rem / ft;
        r2  = rem - tx * ft;
        tw  = (w - tx * TILE_SIDE < TILE_SIDE) ? w - tx * TILE_SIDE : TILE_SIDE;
        dy  = r2 / tw;
        dx  = r2 - dy * tw;
        x   = longint'(xf) + tx * TILE_SIDE + dx;
        y   = longint'(yf) + ty * TILE_SIDE + dy;
      end
      e.x     = x[COORD_W-1:0];
      e.y     = y[COORD_W-1:0];
      e.total = (tot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot[POS_W-1:0];
      due_q.insert(due_q.size(), e);
    endfunction

    // Compare one result word with the oldest one due; empty string if it matches.
    function string check_word(pixel_word_t got);
      pixel_word_t e;
      string       msg;
      if (due_q.size() == 0)
        return $sformatf("unexpected word x=%0d y=%0d", got.x, got.y);
      e   = due_q.pop_front();
      msg = "";
      if (got.x !== e.x) msg = {msg, $sformatf(" x %0d/%0d", got.x, e.x)};
      if (got.y !== e.y) msg = {msg, $sformatf(" y %0d/%0d", got.y, e.y)};
      if (got.in_range !== e.in_range)
        msg = {msg, $sformatf(" in_range %0b/%0b", got.in_range, e.in_range)};
      if (got.total !== e.total)
        msg = {msg, $sformatf(" total %0h/%0h", got.total, e.total)};
      if (msg != "") msg = {"mismatch (got/exp):", msg};
      return msg;
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CIDX_W-1:0]  cfg_index_i;
  logic [CDAT_W-1:0]  cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [POS_W-1:0]   sample_position_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [COORD_W-1:0] pixel_x_o;
  logic [COORD_W-1:0] pixel_y_o;
  logic               in_range_o;
  logic [POS_W-1:0]   total_samples_o;

  pixel_scoreboard sb;
  int unsigned     mismatches;
  int unsigned     hang_count;
  bit              no_idle;

  tiled_pixel_order_mapper uut (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Write one register and update the predictor's copy.
  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CDAT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val[CDAT_W-1:0]);
  endtask

  // Stop sending, wait for every due word, then load a whole window setting.
  task automatic load_window(int unsigned l2, int unsigned xf, int unsigned xl,
                             int unsigned yf, int unsigned yl);
    in_valid_i <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    write_reg(CFG_LOG2_SAMPLES, l2);
    write_reg(CFG_WINDOW_X_FIRST, xf);
    write_reg(CFG_WINDOW_X_LIMIT, xl);
    write_reg(CFG_WINDOW_Y_FIRST, yf);
    write_reg(CFG_WINDOW_Y_LIMIT, yl);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one word after a random gap and note it once accepted.
  task automatic send_position(logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sample_position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_position(pos);
  endtask

  // Position drawn mostly inside the window, some at its end, some anywhere.
  function automatic logic [POS_W-1:0] pick_position();
    longint unsigned tot, lim;
    int unsigned     pick;
    tot  = sb.exact_total();
    lim  = (tot > 64'h1_0000_0000) ? 64'h1_0000_0000 : tot;
    pick = $urandom_range(0, 99);
    if (lim != 0 && pick < 65)
      return POS_W'({$urandom, $urandom} % lim);
    if (lim != 0 && pick < 80)
      return POS_W'(lim - 1 + $urandom_range(0, 2));
    return $urandom;
  endfunction

  // Receiver stall pattern.
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    pixel_word_t got;
    string       msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.x        = pixel_x_o;
      got.y        = pixel_y_o;
      got.in_range = in_range_o;
      got.total    = total_samples_o;
      msg = sb.check_word(got);
      if (msg != "") report(msg);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      hang_count <= 0;
    else if (hang_count >= HANG_LIMIT) begin
      $display("timeout @%0t", $time);
      $display("FAIL");
      $finish;
    end else
      hang_count <= hang_count + 1;
  end

  // Stimulus.
  initial begin
    int unsigned      w, h;
    logic [POS_W-1:0] probes [9];
    sb                = new();
    mismatches        = 0;
    hang_count        = 0;
    no_idle           = 1'b0;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    sample_position_i = '0;
    sb.set_reg(CFG_LOG2_SAMPLES, 0);
    sb.set_reg(CFG_WINDOW_X_FIRST, 0);
    sb.set_reg(CFG_WINDOW_X_LIMIT, 0);
    sb.set_reg(CFG_WINDOW_Y_FIRST, 0);
    sb.set_reg(CFG_WINDOW_Y_LIMIT, 0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty window after reset: nothing is in range.
    send_position(32'h0);
    send_position(32'hFFFF_FFFF);

    // Clipped right and bottom tiles.
    load_window(0, 3, 70, 5, 41);
    probes = '{32'd0, 32'd1, 32'd31, 32'd32, 32'd2143, 32'd2144, 32'd2411,
               32'd2412, 32'hFFFF_FFFF};
    foreach (probes[i])
      send_position(probes[i]);

    // Largest window with a saturated total; every position is in range.
    load_window(16, 0, 16384, 0, 16384);
    send_position(32'h0);
    send_position(32'hFFFF_FFFF);
    send_position(32'h8000_0000);

    // Largest shift and coordinates past 14 bits.
    load_window(31, 16383, 32767, 0, 1);
    send_position(32'h0);
    send_position(32'h7FFF_FFFF);
    send_position(32'h8000_0000);
    send_position(32'hFFFF_FFFF);

    // Limit below first value.
    load_window(2, 100, 40, 7, 300);
    send_position(32'h0);
    send_position(32'h5);

    // Random windows.
    for (int ph = 0; ph < 12; ph++) begin
      int unsigned l2, xf, yf;
      case ($urandom_range(0, 4))
        0: l2 = 0;
        1: l2 = 16;
        2: l2 = 31;
        default: l2 = $urandom_range(0, 6);
      endcase
      xf = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 64);
      yf = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 64);
      w  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 150);
      h  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 150);
      if ($urandom_range(0, 7) == 0) begin
        xf = 0;
        w  = 32767;
      end
      no_idle = (ph % 4 == 3);
      load_window(l2, xf, (xf + w > 32767) ? 32767 : xf + w,
                  yf, (yf + h > 32767) ? 32767 : yf + h);
      repeat (102) send_position(pick_position());
    end
    in_valid_i <= 1'b0;

    // Drain.
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.due_q.size() != 0) report("words left undelivered");
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
